### sv/acp_pkg.sv
// Package for the ASCII CAN line parser.
// Holds character codes, identifier limits, the hex digit decoder and the result type.
// No dependencies.
package acp_pkg;

  // Type letters
  localparam logic [7:0] ChStdData = 8'h74;  // 't'
  localparam logic [7:0] ChStdRtr  = 8'h72;  // 'r'
  localparam logic [7:0] ChExtData = 8'h54;  // 'T'
  localparam logic [7:0] ChExtRtr  = 8'h52;  // 'R'

  // Length digit range and blank threshold
  localparam logic [7:0] ChZero  = 8'h30;    // '0'
  localparam logic [7:0] ChEight = 8'h38;    // '8'
  localparam logic [7:0] ChSpace = 8'h20;

  // Identifier rules
  localparam logic [7:0] StdFirstMax = 8'h7f;
  localparam logic [7:0] ExtFirstMax = 8'h3f;
  localparam logic [3:0] StdIdDigits = 4'd3;
  localparam logic [3:0] ExtIdDigits = 4'd8;

  localparam int unsigned IdW  = 30;
  localparam int unsigned LenW = 4;
  localparam int unsigned PayW = 64;

  // Result word handed from the parser to the output register
  typedef struct packed {
    logic            ok;
    logic [IdW-1:0]  id;
    logic            ext;
    logic            rtr;
    logic [LenW-1:0] len;
    logic [PayW-1:0] data;
  } result_t;

  // Decode one hex character: bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### sv/ascii_can_line_parser.sv
// ASCII CAN line parser: one character word in, one frame result word per line out.
// A line's result is loaded into the output register when its last character leaves the input register.
// Throughput: one character per cycle; the input register stalls only while a
// finished result waits in the output register and the held character ends a line.
// Reset: asynchronous, active low; empties both registers and returns the parser to
// waiting for a type letter.
module ascii_can_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic [29:0] frame_id_o,
  output logic        extended_o,
  output logic        remote_o,
  output logic [3:0]  data_length_o,
  output logic [63:0] payload_o
);

  logic             held_valid;
  logic [7:0]       held_char;
  logic             held_eol;
  logic             adv;
  logic             slot_free;
  acp_pkg::result_t core_res;
  acp_pkg::result_t out_res;

  // Move the held character on unless it ends a line and the result slot is full
  assign adv = held_valid && (!held_eol || slot_free);

  acp_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .char_i  (char_code_i),
    .eol_i   (end_of_line_i),
    .adv_i   (adv),
    .valid_o (held_valid),
    .char_o  (held_char),
    .eol_o   (held_eol)
  );

  acp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .char_i (held_char),
    .eol_i  (held_eol),
    .res_o  (core_res)
  );

  acp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && held_eol),
    .res_i   (core_res),
    .free_o  (slot_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign frame_ok_o    = out_res.ok;
  assign frame_id_o    = out_res.id;
  assign extended_o    = out_res.ext;
  assign remote_o      = out_res.rtr;
  assign data_length_o = out_res.len;
  assign payload_o     = out_res.data;

  // A failed line carries all-zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_ok_o |-> frame_id_o == 30'd0 && !extended_o && !remote_o &&
    data_length_o == 4'd0 && payload_o == 64'd0)
    else $error("failed line result has nonzero fields");

  // A good frame never claims more than eight bytes
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o |-> data_length_o <= 4'd8)
    else $error("data length above eight");

  // A standard identifier fits in eleven bits
  a_std_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o && !extended_o |-> frame_id_o[29:11] == 19'd0)
    else $error("standard identifier too wide");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

### sv/acp_in_reg.sv
// Input register of the ASCII CAN line parser.
// Captures one character word; uses acp_pkg for nothing but shares its style.
module acp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  input  logic       eol_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eol_o
);

  logic       valid_q;
  logic [7:0] char_q;
  logic       eol_q;

  // Take a new word when empty or when the held word moves on
  assign ready_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload until the next word is taken
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      char_q <= char_i;
      eol_q  <= eol_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eol_o   = eol_q;

endmodule

### sv/acp_core.sv
// Parse state of the ASCII CAN line parser: one character per step.
// Depends on acp_pkg for character codes, hex decoding and result_t.
module acp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic             eol_i,
  output acp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhType,
    PhId,
    PhLen,
    PhData,
    PhDone
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [acp_pkg::IdW-1:0]    id_q, id_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [3:0]                 hold_q, hold_d;
  logic [acp_pkg::LenW-1:0]   len_q, len_d;
  logic [acp_pkg::PayW-1:0]   pay_q, pay_d;
  logic                       ext_q, ext_d;
  logic                       rtr_q, rtr_d;
  logic                       err_q, err_d;

  logic [4:0] hex;
  logic [7:0] byte_val;
  logic [2:0] byte_idx;
  logic       ok;

  assign hex      = acp_pkg::hex_digit(char_i);
  assign byte_val = {hold_q, hex[3:0]};
  assign byte_idx = cnt_q[3:1];

  // Apply one character to the line state
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    len_d   = len_q;
    pay_d   = pay_q;
    ext_d   = ext_q;
    rtr_d   = rtr_q;
    err_d   = err_q;
    if (char_i > acp_pkg::ChSpace && !err_q) begin
      case (phase_q)
        PhType: begin
          if (char_i == acp_pkg::ChStdData || char_i == acp_pkg::ChStdRtr ||
              char_i == acp_pkg::ChExtData || char_i == acp_pkg::ChExtRtr) begin
            ext_d   = (char_i == acp_pkg::ChExtData) || (char_i == acp_pkg::ChExtRtr);
            rtr_d   = (char_i == acp_pkg::ChStdRtr) || (char_i == acp_pkg::ChExtRtr);
            phase_d = PhId;
            cnt_d   = '0;
          end else begin
            err_d = 1'b1;
          end
        end
        PhId: begin
          if (hex[4]) begin
            err_d = 1'b1;
          end else begin
            id_d  = {id_q[acp_pkg::IdW-5:0], hex[3:0]};
            cnt_d = cnt_q + 5'd1;
            // First byte range check after the second digit
            if (cnt_d == 5'd2 && id_d[7:0] >
                (ext_q ? acp_pkg::ExtFirstMax : acp_pkg::StdFirstMax)) begin
              err_d = 1'b1;
            end else if (cnt_d[3:0] ==
                         (ext_q ? acp_pkg::ExtIdDigits : acp_pkg::StdIdDigits)) begin
              phase_d = PhLen;
              cnt_d   = '0;
            end
          end
        end
        PhLen: begin
          if (char_i < acp_pkg::ChZero || char_i > acp_pkg::ChEight) begin
            err_d = 1'b1;
          end else begin
            len_d   = char_i[3:0];
            cnt_d   = '0;
            phase_d = (char_i[3:0] == 4'd0) ? PhDone : PhData;
          end
        end
        PhData: begin
          if (hex[4]) begin
            err_d = 1'b1;
          end else begin
            if (!cnt_q[0]) begin
              hold_d = hex[3:0];
            end else begin
              pay_d[8*byte_idx +: 8] = pay_q[8*byte_idx +: 8] | byte_val;
            end
            cnt_d = cnt_q + 5'd1;
            if (cnt_d >= {len_q, 1'b0}) begin
              phase_d = PhDone;
            end
          end
        end
        PhDone: begin
          // ignore trailing characters
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  // Build the line result from the updated state; zero all fields on failure
  assign ok = !err_d && (phase_d == PhDone);
  always_comb begin
    res_o.ok   = ok;
    res_o.id   = ok ? id_d  : '0;
    res_o.ext  = ok ? ext_d : 1'b0;
    res_o.rtr  = ok ? rtr_d : 1'b0;
    res_o.len  = ok ? len_d : '0;
    res_o.data = ok ? pay_d : '0;
  end

  // Advance on each step; clear everything after the last character of a line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      id_q    <= '0;
      cnt_q   <= '0;
      hold_q  <= '0;
      len_q   <= '0;
      pay_q   <= '0;
      ext_q   <= 1'b0;
      rtr_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      if (eol_i) begin
        phase_q <= PhType;
        id_q    <= '0;
        cnt_q   <= '0;
        hold_q  <= '0;
        len_q   <= '0;
        pay_q   <= '0;
        ext_q   <= 1'b0;
        rtr_q   <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        id_q    <= id_d;
        cnt_q   <= cnt_d;
        hold_q  <= hold_d;
        len_q   <= len_d;
        pay_q   <= pay_d;
        ext_q   <= ext_d;
        rtr_q   <= rtr_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

### sv/acp_out_reg.sv
// Result register of the ASCII CAN line parser.
// Holds one result word until taken; depends on acp_pkg::result_t.
module acp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  acp_pkg::result_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output acp_pkg::result_t res_o
);

  logic             valid_q;
  acp_pkg::result_t res_q;

  // Slot is free when empty or emptied this cycle
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### verif/tb_ascii_can_line_parser.sv
// Testbench for ascii_can_line_parser: directed and random text lines go in, frame results
// are checked against a cycle-free line predictor kept here.
// Depends on acp_pkg (character codes, identifier limits, result_t) and the parser RTL.
module tb_ascii_can_line_parser;

  localparam int unsigned RandomWords   = 560;
  localparam int unsigned MaxIdle       = 18;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned LongHoldAt    = 6;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 3000;

  // Hex letter bounds, used both to decode and to spell digits
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;

  typedef enum logic [2:0] {
    LpType,
    LpId,
    LpLen,
    LpData,
    LpDone
  } line_phase_e;

  typedef struct {
    logic [7:0] code;
    logic       eol;
  } char_word_t;

  typedef struct {
    acp_pkg::result_t frame;
    int               stamp;
  } frame_due_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        end_of_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        frame_ok_o;
  logic [29:0] frame_id_o;
  logic        extended_o;
  logic        remote_o;
  logic [3:0]  data_length_o;
  logic [63:0] payload_o;

  char_word_t  char_words[$];
  frame_due_t  frames_due[$];
  logic [7:0]  line_buf[$];
  int          total_words;
  int          words_taken;
  int          frames_taken;
  int          mismatches;
  int          cycle_no;

  // Predictor state for the line being parsed
  line_phase_e lp_phase;
  logic [29:0] lp_id;
  logic [4:0]  lp_cnt;
  logic [3:0]  lp_hold;
  logic [3:0]  lp_len;
  logic [63:0] lp_pay;
  logic        lp_ext;
  logic        lp_rtr;
  logic        lp_err;

  ascii_can_line_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_ok_o    (frame_ok_o),
    .frame_id_o    (frame_id_o),
    .extended_o    (extended_o),
    .remote_o      (remote_o),
    .data_length_o (data_length_o),
    .payload_o     (payload_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  // ---------------------------------------------------------------- predictor

  // Return the digit value, or bit 4 set for a non-hex character
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= acp_pkg::ChZero && c <= ChNine) return {1'b0, 4'(c - acp_pkg::ChZero)};
    if (c >= ChLowA && c <= ChLowF) return {1'b0, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpF) return {1'b0, 4'(c - ChUpA + 8'd10)};
    return 5'h10;
  endfunction

  task automatic clear_line();
    lp_phase = LpType;
    lp_id    = '0;
    lp_cnt   = '0;
    lp_hold  = '0;
    lp_len   = '0;
    lp_pay   = '0;
    lp_ext   = 1'b0;
    lp_rtr   = 1'b0;
    lp_err   = 1'b0;
  endtask

  // Advance the line state by one non-blank character
  task automatic absorb_char(logic [7:0] c);
    logic [4:0] h;
    h = nibble_of(c);
    if (lp_err || lp_phase == LpDone) return;
    case (lp_phase)
      LpType: begin
        if (c == acp_pkg::ChStdData || c == acp_pkg::ChStdRtr ||
            c == acp_pkg::ChExtData || c == acp_pkg::ChExtRtr) begin
          lp_ext   = (c == acp_pkg::ChExtData || c == acp_pkg::ChExtRtr);
          lp_rtr   = (c == acp_pkg::ChStdRtr || c == acp_pkg::ChExtRtr);
          lp_phase = LpId;
          lp_cnt   = '0;
        end else begin
          lp_err = 1'b1;
        end
      end
      LpId: begin
        if (h[4]) begin
          lp_err = 1'b1;
        end else begin
          lp_id  = {lp_id[25:0], h[3:0]};
          lp_cnt = lp_cnt + 5'd1;
          if (lp_cnt == 5'd2 &&
              lp_id > (lp_ext ? acp_pkg::ExtFirstMax : acp_pkg::StdFirstMax)) begin
            lp_err = 1'b1;
          end else if (lp_cnt ==
                       {1'b0, (lp_ext ? acp_pkg::ExtIdDigits : acp_pkg::StdIdDigits)}) begin
            lp_phase = LpLen;
            lp_cnt   = '0;
          end
        end
      end
      LpLen: begin
        if (c < acp_pkg::ChZero || c > acp_pkg::ChEight) begin
          lp_err = 1'b1;
        end else begin
          lp_len   = 4'(c - acp_pkg::ChZero);
          lp_cnt   = '0;
          lp_phase = (lp_len == 4'd0) ? LpDone : LpData;
        end
      end
      LpData: begin
        if (h[4]) begin
          lp_err = 1'b1;
        end else begin
          if (!lp_cnt[0]) begin
            lp_hold = h[3:0];
          end else begin
            lp_pay = lp_pay | (64'({lp_hold, h[3:0]}) << (8 * lp_cnt[3:1]));
          end
          lp_cnt = lp_cnt + 5'd1;
          if (lp_cnt >= {lp_len, 1'b0}) lp_phase = LpDone;
        end
      end
      default: lp_err = 1'b1;
    endcase
  endtask

  // Take one accepted word; at end of line queue the frame it predicts
  task automatic predict_word(logic [7:0] c, logic eol);
    frame_due_t d;
    if (c > acp_pkg::ChSpace) absorb_char(c);
    if (eol) begin
      d.frame = '0;
      d.stamp = cycle_no;
      if (!lp_err && lp_phase == LpDone) begin
        d.frame.ok   = 1'b1;
        d.frame.id   = lp_id;
        d.frame.ext  = lp_ext;
        d.frame.rtr  = lp_rtr;
        d.frame.len  = lp_len;
        d.frame.data = lp_pay;
      end
      frames_due.push_back(d);
      clear_line();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return acp_pkg::ChZero + 8'(v);
    return ($urandom_range(0, 1) ? ChLowA : ChUpA) + 8'(v - 4'd10);
  endfunction

  task automatic put_char(logic [7:0] c, bit blanks);
    if (blanks && $urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 32)));
    line_buf.push_back(c);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Move the line into the word queue, end of line on its last character
  task automatic close_line();
    char_word_t w;
    if (line_buf.size() == 0) line_buf.push_back(acp_pkg::ChSpace);
    else if ($urandom_range(0, 5) == 0) line_buf.push_back(8'($urandom_range(0, 32)));
    foreach (line_buf[i]) begin
      w.code = line_buf[i];
      w.eol  = (i == line_buf.size() - 1);
      char_words.push_back(w);
    end
    line_buf.delete();
  endtask

  task automatic make_frame(bit ext, bit rtr, logic [31:0] id, int len, logic [63:0] data,
                            bit blanks);
    int nd;
    nd = ext ? 8 : 3;
    put_char(ext ? (rtr ? acp_pkg::ChExtRtr : acp_pkg::ChExtData)
                 : (rtr ? acp_pkg::ChStdRtr : acp_pkg::ChStdData), blanks);
    for (int i = nd - 1; i >= 0; i--) put_char(hex_char(id[4*i +: 4]), blanks);
    put_char(acp_pkg::ChZero + 8'(len), blanks);
    for (int k = 0; k < len; k++) begin
      put_char(hex_char(data[8*k+4 +: 4]), blanks);
      put_char(hex_char(data[8*k +: 4]), blanks);
    end
  endtask

  // Mostly well-formed frames with random content, then truncated, corrupted,
  // out-of-range identifier and pure noise lines
  task automatic add_random_line();
    int          kind;
    int          len;
    int          keep;
    bit          ext;
    bit          rtr;
    bit          blanks;
    logic [31:0] id;
    logic [63:0] data;
    kind   = $urandom_range(0, 99);
    ext    = $urandom_range(0, 1);
    rtr    = $urandom_range(0, 1);
    len    = $urandom_range(0, 8);
    blanks = ($urandom_range(0, 3) == 0);
    data   = {$urandom, $urandom};
    id     = ext ? ($urandom & 32'h3fff_ffff) : $urandom_range(0, 12'h7ff);
    case ($urandom_range(0, 7))
      0: id = ext ? 32'h3fff_ffff : 32'h0000_07ff;
      1: id = '0;
      default: ;
    endcase
    if (kind >= 85 && kind < 93) begin
      id = ext ? {8'($urandom_range(8'h40, 8'hff)), 24'($urandom)}
               : $urandom_range(12'h800, 12'hfff);
    end
    if (kind >= 93) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
    end else begin
      make_frame(ext, rtr, id, len, data, blanks);
      if (kind < 60) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
        end
      end else if (kind < 75) begin
        keep = $urandom_range(0, line_buf.size() - 1);
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end else if (kind < 85) begin
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
      end
    end
    close_line();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycle_no, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------- driver

  // Offer words from the queue, idling a drawn number of cycles between them
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    int         tx_wait;
    bit         tx_calm;
    char_word_t w;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      char_code_i   <= 8'h00;
      end_of_line_i <= 1'b0;
      tx_wait = 0;
      tx_calm = 1'b0;
      clear_line();
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_word(char_code_i, end_of_line_i);
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (char_words.size() != 0) begin
          w = char_words.pop_front();
          char_code_i   <= w.code;
          end_of_line_i <= w.eol;
          in_valid_i    <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_wait = tx_calm ? 0 :
                    ($urandom_range(0, 2) == 0 ? $urandom_range(0, MaxIdle) : $urandom_range(0, 1));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Check each accepted frame against the oldest prediction; stall ready at random
  always @(posedge clk_i or negedge rst_ni) begin : watch_frames
    int         rx_wait;
    bit         rx_calm;
    frame_due_t d;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
      rx_calm = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0 || frames_due[0].stamp >= cycle_no) begin
          report_mismatch("frame with no line pending");
        end else begin
          d = frames_due.pop_front();
          check_field("frame_ok", 64'(frame_ok_o), 64'(d.frame.ok));
          check_field("frame_id", 64'(frame_id_o), 64'(d.frame.id));
          check_field("extended", 64'(extended_o), 64'(d.frame.ext));
          check_field("remote", 64'(remote_o), 64'(d.frame.rtr));
          check_field("data_length", 64'(data_length_o), 64'(d.frame.len));
          check_field("payload", payload_o, d.frame.data);
        end
        frames_taken++;
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, MaxIdle);
        // Hold off once long enough for the parser to back up its input
        if (frames_taken == LongHoldAt) rx_wait = LongHold;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin : watchdog
    int stuck;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
      if (stuck >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int directed;
    words_taken  = 0;
    frames_taken = 0;
    mismatches   = 0;
    cycle_no     = 0;

    // Directed lines: extremes, every type letter and each failure kind
    put_str("t0000"); close_line();
    put_str("t7FF8FFFFFFFFFFFFFFFF"); close_line();
    put_str("T000000000"); close_line();
    put_str("R3FFFFFFF0"); close_line();
    put_str("T3fffffff80123456789abcdefABCDEF"); close_line();
    put_str("r1230"); close_line();
    put_str("t8000"); close_line();
    put_str("T400000000"); close_line();
    put_str("x1230"); close_line();
    put_str("t12G0"); close_line();
    put_str("t1239"); close_line();
    put_str("t123/"); close_line();
    put_str("t12"); close_line();
    put_str("t1232AB"); close_line();
    line_buf.push_back(8'h00); line_buf.push_back(8'h09); line_buf.push_back(acp_pkg::ChSpace);
    close_line();
    put_str("t1231AG"); close_line();
    put_str("t1231aaz"); line_buf.push_back(8'hff); line_buf.push_back(8'h80); close_line();
    line_buf.push_back(8'hff); put_str("1230"); close_line();
    put_str("t 1 2 3"); line_buf.push_back(8'h00); put_str("2 a b c d"); close_line();
    put_str("t1232aBcD"); line_buf.push_back(acp_pkg::ChSpace); close_line();
    put_str("t1231"); line_buf.push_back(8'hff); put_str("A"); close_line();
    directed = char_words.size();

    while (char_words.size() < directed + RandomWords) add_random_line();
    total_words = char_words.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken != total_words || frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### ascii_can_line_parser.f
sv/acp_pkg.sv
sv/acp_in_reg.sv
sv/acp_core.sv
sv/acp_out_reg.sv
sv/ascii_can_line_parser.sv
verif/tb_ascii_can_line_parser.sv
